FILE: rtl/core/cdconv_pkg.sv
package cdconv_pkg;

    // Depth of both conversion pipelines, input register to result register
    localparam int LATENCY    = 8;
    localparam int FWD_STAGES = 5;
    localparam int FWD_PAD    = LATENCY - FWD_STAGES;

    // Day count offsets
    localparam int unsigned EPOCH_SHIFT  = 719468;
    localparam int unsigned DAYS_PER_ERA = 146097;
    // Epoch shift plus one era: the era index is stored biased by one
    localparam int unsigned FWD_OFFSET   = EPOCH_SHIFT + DAYS_PER_ERA;
    // Epoch shift plus 24 eras: keeps the inverse dividend non-negative
    localparam int unsigned INV_BIAS     = EPOCH_SHIFT + 24 * DAYS_PER_ERA;
    localparam int unsigned INV_ERA_BIAS = 24 * 400;

    // Reciprocals: M = ceil(2^k / d), k = operand bits + clog2(d),
    // so that (v * M) >> k equals v / d over the whole operand range.
    localparam logic [15:0] M_DIV400    = 16'(((64'd1 << 24) + 64'd399) / 64'd400);
    localparam logic [14:0] M_DIV25     = 15'(((64'd1 << 19) + 64'd24) / 64'd25);
    localparam logic [14:0] M_DIV125    = 15'(((64'd1 << 21) + 64'd124) / 64'd125);
    localparam logic [18:0] M_MOD7      = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
    localparam logic [24:0] M_ERA       = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
    localparam logic [18:0] M_DIV1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_DIV36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_DIV146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
    localparam logic [18:0] M_DIV365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [11:0] M_DIV153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic signed [22:0] day_number;
        logic               date_valid;
        logic [2:0]         weekday;
    } t_fwd_res;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
    } t_inv_res;

    typedef struct packed {
        t_fwd_res fwd;
        t_inv_res inv;
    } t_result;

    // First day of each month in a March-based year, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length in a common year, January is 1
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] r;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
            4'd2:                                      r = 5'd28;
            default:                                   r = 5'd0;
        endcase
        return r;
    endfunction

    // yoe / 100 for a year of era below 400
    function automatic logic [1:0] hundreds_of(input logic [8:0] yoe);
        return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    endfunction

endpackage

FILE: rtl/core/cdconv_fwd.sv
// Civil date to day number, validity and weekday
module cdconv_fwd (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [13:0]           i_year,
    input  logic [3:0]            i_month,
    input  logic [4:0]            i_day,
    output cdconv_pkg::t_fwd_res  o_res
);

    // stage 1: shifted year, day of year, reciprocal products
    logic              early;
    logic              mok;
    logic [14:0]       v;
    logic [3:0]        mp;
    logic signed [9:0] doy;

    logic [14:0]       r1_v;
    logic [30:0]       r1_p400;
    logic [28:0]       r1_p25;
    logic [28:0]       r1_p125;
    logic [13:0]       r1_year;
    logic [4:0]        r1_day;
    logic [4:0]        r1_mlen;
    logic              r1_feb;
    logic              r1_mok;
    logic signed [9:0] r1_doy;

    assign mok   = (i_month >= 4'd1) && (i_month <= 4'd12);
    assign early = (i_month <= 4'd2);
    assign v     = 15'(i_year) + 15'd400 - 15'(early);
    assign mp    = early ? i_month + 4'd9 : i_month - 4'd3;
    assign doy   = $signed({1'b0, cdconv_pkg::month_start(mp)})
                 + $signed({5'd0, i_day}) - 10'sd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v    <= v;
            r1_p400 <= 31'(v) * 31'(cdconv_pkg::M_DIV400);
            r1_p25  <= 29'(i_year) * 29'(cdconv_pkg::M_DIV25);
            r1_p125 <= 29'(i_year) * 29'(cdconv_pkg::M_DIV125);
            r1_year <= i_year;
            r1_day  <= i_day;
            r1_mlen <= cdconv_pkg::month_len(i_month);
            r1_feb  <= (i_month == 4'd2);
            r1_mok  <= mok;
            r1_doy  <= doy;
        end
    end

    // stage 2: era and year of era, leap rule with the 4000-year exception
    logic [5:0]  q400;
    logic [8:0]  yoe;
    logic [9:0]  q25;
    logic [7:0]  q125;
    logic        z25;
    logic        z125;
    logic        leap;
    logic [4:0]  len;
    logic        valid;

    logic [8:0]        r2_yoe;
    logic [5:0]        r2_q400;
    logic signed [9:0] r2_doy;
    logic              r2_valid;
    logic              r2_mok;

    assign q400  = r1_p400[29:24];
    assign yoe   = 9'(r1_v - 15'(q400) * 15'd400);
    assign q25   = r1_p25[28:19];
    assign q125  = r1_p125[28:21];
    assign z25   = (r1_year == 14'(14'(q25) * 14'd25));
    assign z125  = (r1_year == 14'(14'(q125) * 14'd125));
    assign leap  = (r1_year[1:0] == 2'd0)
                && (!z25 || ((r1_year[3:0] == 4'd0) && !((r1_year[4:0] == 5'd0) && z125)));
    assign len   = r1_mlen + 5'(r1_feb && leap);
    assign valid = r1_mok && (r1_day != 5'd0) && (r1_day <= len);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_yoe   <= yoe;
            r2_q400  <= q400;
            r2_doy   <= r1_doy;
            r2_valid <= valid;
            r2_mok   <= r1_mok;
        end
    end

    // stage 3: day of era
    logic [17:0]        base;
    logic signed [18:0] r3_doe;
    logic [5:0]         r3_q400;
    logic               r3_valid;
    logic               r3_mok;

    assign base = 18'(r2_yoe) * 18'd365 + 18'(r2_yoe[8:2])
                - 18'(cdconv_pkg::hundreds_of(r2_yoe));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_doe   <= $signed({1'b0, base}) + 19'(r2_doy);
            r3_q400  <= r2_q400;
            r3_valid <= r2_valid;
            r3_mok   <= r2_mok;
        end
    end

    // stage 4: day number; weekday reduction product (an era is whole weeks,
    // and day zero of an era is a Wednesday)
    logic signed [31:0] dn;
    logic [17:0]        s;

    logic signed [22:0] r4_dn;
    logic [17:0]        r4_s;
    logic [36:0]        r4_pw;
    logic               r4_valid;
    logic               r4_mok;

    assign dn = $signed({26'd0, r3_q400}) * 32'sd146097 + 32'(r3_doe)
              - $signed(32'(cdconv_pkg::FWD_OFFSET));
    assign s  = 18'(r3_doe + 19'sd3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dn    <= dn[22:0];
            r4_s     <= s;
            r4_pw    <= 37'(s) * 37'(cdconv_pkg::M_MOD7);
            r4_valid <= r3_valid;
            r4_mok   <= r3_mok;
        end
    end

    // stage 5: weekday remainder, zero the fields for a month out of range
    logic [14:0] q7;
    logic [2:0]  wd;
    cdconv_pkg::t_fwd_res r5_res;

    assign q7 = r4_pw[35:21];
    assign wd = 3'(r4_s - 18'(q7) * 18'd7);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_res.day_number <= r4_mok ? r4_dn : 23'sd0;
            r5_res.date_valid <= r4_valid;
            r5_res.weekday    <= r4_mok ? wd : 3'd0;
        end
    end

    // balance latency against the inverse path
    cdconv_pkg::t_fwd_res r_dly [cdconv_pkg::FWD_PAD];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r5_res;
            for (int i = 1; i < cdconv_pkg::FWD_PAD; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_res = r_dly[cdconv_pkg::FWD_PAD-1];

endmodule

FILE: rtl/core/cdconv_inv.sv
// Day count to civil date
module cdconv_inv (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [22:0]    i_day_count,
    output cdconv_pkg::t_inv_res  o_res
);

    // stage 1: biased dividend and era product
    logic [23:0] w;
    logic [23:0] r1_w;
    logic [48:0] r1_p;

    assign w = 24'(25'(i_day_count) + $signed(25'(cdconv_pkg::INV_BIAS)));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_w <= w;
            r1_p <= 49'(w) * 49'(cdconv_pkg::M_ERA);
        end
    end

    // stage 2: era (biased) and day of era
    logic [5:0]  q;
    logic [5:0]  r2_q;
    logic [17:0] r2_doe;

    assign q = r1_p[47:42];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_q   <= q;
            r2_doe <= 18'(r1_w - 24'(q) * 24'd146097);
        end
    end

    // stage 3: leap correction products
    logic [36:0] r3_a;
    logic [36:0] r3_b;
    logic [36:0] r3_c;
    logic [17:0] r3_doe;
    logic [5:0]  r3_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_a   <= 37'(r2_doe) * 37'(cdconv_pkg::M_DIV1460);
            r3_b   <= 37'(r2_doe) * 37'(cdconv_pkg::M_DIV36524);
            r3_c   <= 37'(r2_doe) * 37'(cdconv_pkg::M_DIV146096);
            r3_doe <= r2_doe;
            r3_q   <= r2_q;
        end
    end

    // stage 4: day of era with leap days taken out
    logic [17:0] r4_t;
    logic [17:0] r4_doe;
    logic [5:0]  r4_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_t   <= r3_doe - 18'(r3_a[35:29]) + 18'(r3_b[36:34]) - 18'(r3_c[36]);
            r4_doe <= r3_doe;
            r4_q   <= r3_q;
        end
    end

    // stage 5: year of era product
    logic [36:0] r5_p;
    logic [17:0] r5_doe;
    logic [5:0]  r5_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_p   <= 37'(r4_t) * 37'(cdconv_pkg::M_DIV365);
            r5_doe <= r4_doe;
            r5_q   <= r4_q;
        end
    end

    // stage 6: year of era and day of year
    logic [8:0]  yoe;
    logic [17:0] base;
    logic [8:0]  r6_yoe;
    logic [8:0]  r6_doy;
    logic [5:0]  r6_q;

    assign yoe  = r5_p[35:27];
    assign base = 18'(yoe) * 18'd365 + 18'(yoe[8:2])
                - 18'(cdconv_pkg::hundreds_of(yoe));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_yoe <= yoe;
            r6_doy <= 9'(r5_doe - base);
            r6_q   <= r5_q;
        end
    end

    // stage 7: month product
    logic [10:0] x;
    logic [22:0] r7_p;
    logic [8:0]  r7_doy;
    logic [8:0]  r7_yoe;
    logic [5:0]  r7_q;

    assign x = 11'(r6_doy) * 11'd5 + 11'd2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_p   <= 23'(x) * 23'(cdconv_pkg::M_DIV153);
            r7_doy <= r6_doy;
            r7_yoe <= r6_yoe;
            r7_q   <= r6_q;
        end
    end

    // stage 8: month, day and year, January and February fall in the next year
    logic [3:0]         mp;
    logic               late;
    logic signed [16:0] y;
    cdconv_pkg::t_inv_res r8_res;

    assign mp   = r7_p[22:19];
    assign late = (mp >= 4'd10);
    assign y    = $signed({8'd0, r7_yoe}) + $signed({11'd0, r7_q}) * 17'sd400
                - $signed(17'(cdconv_pkg::INV_ERA_BIAS)) + $signed({16'd0, late});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_res.out_year  <= y[13:0];
            r8_res.out_month <= late ? mp - 4'd9 : mp + 4'd3;
            r8_res.out_day   <= 5'(r7_doy - cdconv_pkg::month_start(mp) + 9'd1);
        end
    end

    assign o_res = r8_res;

endmodule

FILE: rtl/core/cdconv_skid.sv
// Output register with one skid entry; room is a registered flag
module cdconv_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cdconv_pkg::t_result  i_data,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cdconv_pkg::t_result  o_data
);

    logic                r_ov;
    logic                r_skv;
    cdconv_pkg::t_result r_out;
    cdconv_pkg::t_result r_sk;
    logic                fire;

    assign fire = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (fire) begin
                r_skv <= 1'b0;
            end
        end else if (i_push) begin
            if (r_ov && !fire) begin
                r_skv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (fire) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skv) begin
            if (fire) begin
                r_out <= r_sk;
            end
        end else if (i_push) begin
            if (r_ov && !fire) begin
                r_sk <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_room  = !r_skv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/civil_date_day_number_converter_unit.sv
// Channel   | Dir | Payload (lowest bit first)                          | Handshake
// ----------+-----+-----------------------------------------------------+-----------------
// s (input) | in  | tdata: year, month, day, day_count, zero pad to 48   | tvalid / tready
// m (result)| out | tdata: day_number, weekday, out_year, out_month,     | tvalid / tready
//           |     |        out_day, zero pad to 56; tuser: date_valid     |
//
// One item a cycle is taken and one result item a cycle leaves while the result
// side keeps accepting; items pass eight pipeline stages plus the output register.
// Both conversions run side by side in eight-stage pipelines, the forward one padded with
// delay stages; most working stages hold one reciprocal multiply, which sets the clock.
// Reset (synchronous, active low) clears the stage valid bits and the output
// register flags; payload registers are not reset.
// A stalled result side fills the output register and then the skid entry;
// only then does the whole pipeline hold and tready on the input side drop.
module civil_date_day_number_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // year[13:0], month[17:14], day[22:18], day_count[45:23]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,    // day_number[22:0], weekday[25:23], out_year[39:26],
                                      // out_month[43:40], out_day[48:44]
    output logic [0:0]  o_m_tuser     // date_valid[0]
);

    localparam int LAT = cdconv_pkg::LATENCY;

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    cdconv_pkg::t_fwd_res w_fwd;
    cdconv_pkg::t_inv_res w_inv;
    cdconv_pkg::t_result  w_res;
    cdconv_pkg::t_result  w_out;

    // Advance every stage together whenever the skid entry is free
    assign o_s_tready = w_en;

    // Track which stages hold a live item; bubbles travel as cleared bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Date to day number, validity and weekday
    cdconv_fwd u_fwd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_s_tdata[13:0]),
        .i_month (i_s_tdata[17:14]),
        .i_day   (i_s_tdata[22:18]),
        .o_res   (w_fwd)
    );

    // Day count back to a date
    cdconv_inv u_inv (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_day_count (i_s_tdata[45:23]),
        .o_res       (w_inv)
    );

    assign w_res.fwd = w_fwd;
    assign w_res.inv = w_inv;

    // Hold finished results apart from the pipeline so it keeps moving
    cdconv_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && r_vld[LAT-1]),
        .i_data  (w_res),
        .o_room  (w_en),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata = {7'd0, w_out.inv.out_day, w_out.inv.out_month, w_out.inv.out_year,
                        w_out.fwd.weekday, w_out.fwd.day_number};
    assign o_m_tuser = w_out.fwd.date_valid;

endmodule
